FILE: rtl/cbcs_pkg.sv
// types and constants shared by the capacitor bank charge sequencer
// no dependencies
`default_nettype none

package cbcs_pkg;

   // command codes carried by an input item
   typedef enum logic [1:0] {
      KIND_UPDATE  = 2'd0,
      KIND_PREPARE = 2'd1,
      KIND_FIRE    = 2'd2,
      KIND_RESET   = 2'd3
   } kind_type;

   // charge sequence states, reported as sequence_code
   typedef enum logic [3:0] {
      SEQ_READY       = 4'd0,
      SEQ_B1_CHARGING = 4'd1,
      SEQ_B1_CHECKING = 4'd2,
      SEQ_B1_FAULT    = 4'd3,
      SEQ_B1_SUCCESS  = 4'd4,
      SEQ_B2_CHARGING = 4'd5,
      SEQ_B2_CHECKING = 4'd6,
      SEQ_B2_FAULT    = 4'd7,
      SEQ_B2_SUCCESS  = 4'd8
   } seq_state_type;

   // register indexes on the configuration port
   typedef enum logic [2:0] {
      CSR_B1_VOLT  = 3'd0,
      CSR_B1_CUR   = 3'd1,
      CSR_B2_VOLT  = 3'd2,
      CSR_B2_CUR   = 3'd3,
      CSR_RESIDUAL = 3'd4
   } csr_index_type;

   localparam int CSR_ADDR_BITS = 5;
   localparam logic [15:0] RESIDUAL_RESET = 16'd10;

   // bit positions in the relay level vector
   localparam int RELAY_ENABLE = 0;
   localparam int RELAY_CHARGE = 1;
   localparam int RELAY_SELECT = 2;
   localparam int RELAY_FIRE   = 3;

   typedef struct packed {
      logic [15:0] bank1_voltage_target;
      logic [15:0] bank1_current_target;
      logic [15:0] bank2_voltage_target;
      logic [15:0] bank2_current_target;
      logic [15:0] residual_threshold;
   } cfg_type;

   typedef struct packed {
      logic          enable_relay;
      logic          charge_relay;
      logic          select_relay;
      logic          fire_relay;
      logic          supply_output_on;
      logic [15:0]   supply_voltage_setpoint;
      logic [15:0]   supply_current_setpoint;
      seq_state_type sequence_code;
      logic          finished;
      logic          fault;
      logic          last;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/cbcs_csr.sv
// configuration registers behind the apb-style port
// depends on cbcs_pkg
`default_nettype none

module cbcs_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [cbcs_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]                        pwdata,
   output logic      [31:0]                        prdata,
   output logic                                    pready,
   output cbcs_pkg::cfg_type                       cfg
);
   import cbcs_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          wr_en;

   assign index  = csr_index_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            CSR_B1_VOLT:  cfg_in.bank1_voltage_target = pwdata[15:0];
            CSR_B1_CUR:   cfg_in.bank1_current_target = pwdata[15:0];
            CSR_B2_VOLT:  cfg_in.bank2_voltage_target = pwdata[15:0];
            CSR_B2_CUR:   cfg_in.bank2_current_target = pwdata[15:0];
            CSR_RESIDUAL: cfg_in.residual_threshold   = pwdata[15:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         CSR_B1_VOLT:  prdata = {16'd0, cfg_ff.bank1_voltage_target};
         CSR_B1_CUR:   prdata = {16'd0, cfg_ff.bank1_current_target};
         CSR_B2_VOLT:  prdata = {16'd0, cfg_ff.bank2_voltage_target};
         CSR_B2_CUR:   prdata = {16'd0, cfg_ff.bank2_current_target};
         CSR_RESIDUAL: prdata = {16'd0, cfg_ff.residual_threshold};
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{bank1_voltage_target: 16'd0, bank1_current_target: 16'd0,
                     bank2_voltage_target: 16'd0, bank2_current_target: 16'd0,
                     residual_threshold: RESIDUAL_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/cbcs_seq.sv
// command register, relay step counter and charge sequence state
// depends on cbcs_pkg
`default_nettype none

module cbcs_seq #(
   parameter int VOLT_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_kind,
   input  wire logic [15:0]          req_sensed_voltage,
   input  wire cbcs_pkg::cfg_type    cfg,
   input  wire logic                 out_ready,
   output logic                      out_push,
   output cbcs_pkg::result_type      out_result
);
   import cbcs_pkg::*;

   // voltages are kept to VOLT_BITS bits, then to the 16-bit fields
   localparam logic [15:0] VMASK = (VOLT_BITS >= 16) ? 16'hFFFF
                                   : 16'((33'd1 << VOLT_BITS) - 33'd1);

   logic          item_valid_ff, item_valid_in;
   kind_type      item_kind_ff, item_kind_in;
   logic [15:0]   item_sensed_ff, item_sensed_in;
   logic [1:0]    step_ff, step_in;

   seq_state_type state_ff, state_in;
   logic [3:0]    relay_ff, relay_in;
   logic          supply_ff, supply_in;
   logic [15:0]   vset_ff, vset_in;
   logic [15:0]   iset_ff, iset_in;

   logic          take;
   logic          fin;
   logic          lst;
   logic          accept;
   logic [15:0]   sensed;

   assign sensed    = item_sensed_ff & VMASK;
   assign take      = item_valid_ff && out_ready;
   assign req_stall = item_valid_ff && !(take && lst);
   assign accept    = req_valid && !req_stall;
   assign out_push  = take;

   // next state of the sequence for the current step
   always_comb begin
      state_in  = state_ff;
      relay_in  = relay_ff;
      supply_in = supply_ff;
      vset_in   = vset_ff;
      iset_in   = iset_ff;
      fin       = 1'b0;
      lst       = 1'b0;
      case (item_kind_ff)
         KIND_PREPARE: begin
            relay_in[RELAY_ENABLE] = 1'b1;
            state_in = SEQ_READY;
            lst = 1'b1;
         end
         KIND_FIRE: begin
            case (step_ff)
               2'd0:    relay_in[RELAY_FIRE] = 1'b1;
               2'd1:    relay_in[RELAY_FIRE] = 1'b0;
               default: begin
                  relay_in[RELAY_ENABLE] = 1'b0;
                  state_in = SEQ_READY;
                  lst = 1'b1;
               end
            endcase
         end
         KIND_RESET: begin
            case (step_ff)
               2'd0:    relay_in[RELAY_FIRE]   = 1'b0;
               2'd1:    relay_in[RELAY_SELECT] = 1'b0;
               2'd2:    relay_in[RELAY_ENABLE] = 1'b0;
               default: begin
                  relay_in[RELAY_CHARGE] = 1'b0;
                  state_in = SEQ_READY;
                  lst = 1'b1;
               end
            endcase
         end
         default: begin
            lst = 1'b1;
            case (state_ff)
               SEQ_B1_CHARGING: begin
                  if (sensed > (cfg.bank1_voltage_target & VMASK)) begin
                     relay_in[RELAY_CHARGE] = 1'b0;
                     supply_in = 1'b0;
                     state_in  = SEQ_B1_CHECKING;
                  end
               end
               SEQ_B2_CHARGING: begin
                  if (sensed > (cfg.bank2_voltage_target & VMASK)) begin
                     relay_in[RELAY_CHARGE] = 1'b0;
                     supply_in = 1'b0;
                     state_in  = SEQ_B2_CHECKING;
                  end
               end
               SEQ_B1_CHECKING: begin
                  state_in = (sensed >= (cfg.residual_threshold & VMASK))
                             ? SEQ_B1_FAULT : SEQ_B1_SUCCESS;
               end
               SEQ_B2_CHECKING: begin
                  state_in = (sensed >= (cfg.residual_threshold & VMASK))
                             ? SEQ_B2_FAULT : SEQ_B2_SUCCESS;
               end
               SEQ_B1_FAULT, SEQ_B2_FAULT: begin
                  supply_in = 1'b0;
                  fin = 1'b1;
               end
               SEQ_B1_SUCCESS: begin
                  relay_in[RELAY_SELECT] = 1'b1;
                  relay_in[RELAY_CHARGE] = 1'b1;
                  vset_in   = cfg.bank2_voltage_target & VMASK;
                  iset_in   = cfg.bank2_current_target;
                  supply_in = 1'b1;
                  state_in  = SEQ_B2_CHARGING;
               end
               SEQ_B2_SUCCESS: fin = 1'b1;
               default: begin
                  relay_in[RELAY_SELECT] = 1'b0;
                  relay_in[RELAY_CHARGE] = 1'b1;
                  vset_in   = cfg.bank1_voltage_target & VMASK;
                  iset_in   = cfg.bank1_current_target;
                  supply_in = 1'b1;
                  state_in  = SEQ_B1_CHARGING;
               end
            endcase
         end
      endcase
   end

   // snapshot after the step
   always_comb begin
      out_result.enable_relay            = relay_in[RELAY_ENABLE];
      out_result.charge_relay            = relay_in[RELAY_CHARGE];
      out_result.select_relay            = relay_in[RELAY_SELECT];
      out_result.fire_relay              = relay_in[RELAY_FIRE];
      out_result.supply_output_on        = supply_in;
      out_result.supply_voltage_setpoint = vset_in;
      out_result.supply_current_setpoint = iset_in;
      out_result.sequence_code           = state_in;
      out_result.finished                = fin;
      out_result.fault = (state_in == SEQ_B1_FAULT) || (state_in == SEQ_B2_FAULT);
      out_result.last                    = lst;
   end

   always_comb begin
      item_valid_in  = item_valid_ff;
      item_kind_in   = item_kind_ff;
      item_sensed_in = item_sensed_ff;
      step_in        = step_ff;
      if (take) begin
         step_in = step_ff + 2'd1;
         if (lst) begin
            item_valid_in = 1'b0;
         end
      end
      if (accept) begin
         item_valid_in  = 1'b1;
         item_kind_in   = kind_type'(req_kind);
         item_sensed_in = req_sensed_voltage;
         step_in        = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         step_ff       <= 2'd0;
         state_ff      <= SEQ_READY;
         relay_ff      <= 4'd0;
         supply_ff     <= 1'b0;
         vset_ff       <= 16'd0;
         iset_ff       <= 16'd0;
      end else begin
         item_valid_ff <= item_valid_in;
         step_ff       <= step_in;
         if (take) begin
            state_ff  <= state_in;
            relay_ff  <= relay_in;
            supply_ff <= supply_in;
            vset_ff   <= vset_in;
            iset_ff   <= iset_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_kind_ff   <= item_kind_in;
      item_sensed_ff <= item_sensed_in;
   end

endmodule

`default_nettype wire

FILE: rtl/cbcs_out.sv
// result register in front of the rsp channel
// depends on cbcs_pkg
`default_nettype none

module cbcs_out (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire cbcs_pkg::result_type push_result,
   output logic                      ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output cbcs_pkg::result_type      rsp_result
);
   import cbcs_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign ready      = !valid_ff || !rsp_stall;
   assign valid_in   = push || (valid_ff && rsp_stall);
   assign data_in    = push ? push_result : data_ff;
   assign rsp_valid  = valid_ff;
   assign rsp_result = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

FILE: rtl/capacitor_bank_charge_sequencer_unit.sv
// top level of the capacitor bank charge sequencer
// depends on cbcs_pkg, cbcs_csr, cbcs_seq, cbcs_out
`default_nettype none

// usage:
// req channel carries one command item (kind, sensed_voltage); rsp channel
// returns one result item per relay step, the final one flagged by last.
// update and prepare give one result, fire three, reset four.
// each step passes through the sequence logic and its result is registered in
// the output register in the cycle after the step. the first result of an item
// passes through the command register and then the output register.
// one command holds the command register through all of its steps (1, 3 or 4),
// and the next item is taken in the cycle the last step leaves,
// so single-step commands run at one item per cycle while rsp_stall is low.
// while rsp_stall is high and the output register is full, it holds its result,
// no step advances, and req_stall rises once the command register is occupied.
// reset (synchronous) empties both registers, sets the sequence to ready,
// opens all relays, switches the supply off with zero setpoints and loads
// the register defaults (residual threshold 10, targets 0). the user writes
// registers over the apb port only while no command is active; not enforced.

module capacitor_bank_charge_sequencer_unit #(
   parameter int VOLT_BITS = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_kind,
   input  wire logic [15:0]                        req_sensed_voltage,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_enable_relay,
   output logic                                    rsp_charge_relay,
   output logic                                    rsp_select_relay,
   output logic                                    rsp_fire_relay,
   output logic                                    rsp_supply_output_on,
   output logic [15:0]                             rsp_supply_voltage_setpoint,
   output logic [15:0]                             rsp_supply_current_setpoint,
   output logic [3:0]                              rsp_sequence_code,
   output logic                                    rsp_finished,
   output logic                                    rsp_fault,
   output logic                                    rsp_last,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [cbcs_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]                        pwdata,
   output logic      [31:0]                        prdata,
   output logic                                    pready
);
   import cbcs_pkg::*;

   cfg_type    cfg;
   logic       out_ready;
   logic       out_push;
   result_type step_result;
   result_type rsp_result;

   cbcs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   cbcs_seq #(
      .VOLT_BITS (VOLT_BITS)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_sensed_voltage (req_sensed_voltage),
      .cfg                (cfg),
      .out_ready          (out_ready),
      .out_push           (out_push),
      .out_result         (step_result)
   );

   cbcs_out u_out (
      .clock       (clock),
      .reset       (reset),
      .push        (out_push),
      .push_result (step_result),
      .ready       (out_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (rsp_result)
   );

   assign rsp_enable_relay            = rsp_result.enable_relay;
   assign rsp_charge_relay            = rsp_result.charge_relay;
   assign rsp_select_relay            = rsp_result.select_relay;
   assign rsp_fire_relay              = rsp_result.fire_relay;
   assign rsp_supply_output_on        = rsp_result.supply_output_on;
   assign rsp_supply_voltage_setpoint = rsp_result.supply_voltage_setpoint;
   assign rsp_supply_current_setpoint = rsp_result.supply_current_setpoint;
   assign rsp_sequence_code           = rsp_result.sequence_code;
   assign rsp_finished                = rsp_result.finished;
   assign rsp_fault                   = rsp_result.fault;
   assign rsp_last                    = rsp_result.last;

endmodule

`default_nettype wire

FILE: rtl/cbcs_checker.sv
// port-level checks for the charge sequencer, bound to the top level
// depends on cbcs_pkg and the capacitor_bank_charge_sequencer_unit ports
`default_nettype none

module cbcs_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [3:0] rsp_sequence_code,
   input wire logic       rsp_finished,
   input wire logic       rsp_fault,
   input wire logic       rsp_last
);
   import cbcs_pkg::*;

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("outputs not empty after reset");

   // fault flag tracks the two error codes
   a_fault_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fault == ((rsp_sequence_code == SEQ_B1_FAULT) ||
                                   (rsp_sequence_code == SEQ_B2_FAULT))))
      else $error("fault flag disagrees with sequence code");

   // a finished result is always flagged last, as update gives a single result
   a_finished_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_last)
      else $error("finished without last");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sequence_code)
                                 && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind capacitor_bank_charge_sequencer_unit cbcs_checker u_cbcs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_sequence_code (rsp_sequence_code),
   .rsp_finished      (rsp_finished),
   .rsp_fault         (rsp_fault),
   .rsp_last          (rsp_last)
);

`default_nettype wire

FILE: tb/cbcs_result_monitor.sv
// watches both channels and the register port of the charge sequencer, keeps its own
// copy of the sequence and relay levels, and compares every result item in order
// depends on cbcs_pkg
`timescale 1ns / 100ps
`default_nettype none

module cbcs_result_monitor (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_stall,
   input  wire logic [1:0]                         req_kind,
   input  wire logic [15:0]                        req_sensed_voltage,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_stall,
   input  wire logic                               rsp_enable_relay,
   input  wire logic                               rsp_charge_relay,
   input  wire logic                               rsp_select_relay,
   input  wire logic                               rsp_fire_relay,
   input  wire logic                               rsp_supply_output_on,
   input  wire logic [15:0]                        rsp_supply_voltage_setpoint,
   input  wire logic [15:0]                        rsp_supply_current_setpoint,
   input  wire logic [3:0]                         rsp_sequence_code,
   input  wire logic                               rsp_finished,
   input  wire logic                               rsp_fault,
   input  wire logic                               rsp_last,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [cbcs_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]                        pwdata,
   input  wire logic                               pready,
   output int                                      outstanding,
   output int                                      fail_count
);
   import cbcs_pkg::*;

   cfg_type       cfg;
   seq_state_type model_state;
   logic [3:0]    relays;
   logic          supply_on;
   logic [15:0]   volt_setpoint;
   logic [15:0]   curr_setpoint;
   result_type    step_results[$];

   function automatic result_type snapshot(logic fin, logic lst);
      result_type r;
      r.enable_relay            = relays[RELAY_ENABLE];
      r.charge_relay            = relays[RELAY_CHARGE];
      r.select_relay            = relays[RELAY_SELECT];
      r.fire_relay              = relays[RELAY_FIRE];
      r.supply_output_on        = supply_on;
      r.supply_voltage_setpoint = volt_setpoint;
      r.supply_current_setpoint = curr_setpoint;
      r.sequence_code           = model_state;
      r.finished                = fin;
      r.fault = (model_state == SEQ_B1_FAULT) || (model_state == SEQ_B2_FAULT);
      r.last                    = lst;
      return r;
   endfunction

   function automatic void begin_charge(logic bank_two, logic [15:0] volts,
                                        logic [15:0] amps, seq_state_type next);
      relays[RELAY_SELECT] = bank_two;
      relays[RELAY_CHARGE] = 1'b1;
      volt_setpoint = volts;
      curr_setpoint = amps;
      supply_on = 1'b1;
      model_state = next;
   endfunction

   // relay steps of one command, one result item each
   function automatic void run_command(kind_type kind, logic [15:0] sensed);
      logic        fin;
      logic [15:0] target;
      fin = 1'b0;
      case (kind)
         KIND_PREPARE: begin
            relays[RELAY_ENABLE] = 1'b1;
            model_state = SEQ_READY;
            step_results.push_back(snapshot(1'b0, 1'b1));
         end
         KIND_FIRE: begin
            relays[RELAY_FIRE] = 1'b1;
            step_results.push_back(snapshot(1'b0, 1'b0));
            relays[RELAY_FIRE] = 1'b0;
            step_results.push_back(snapshot(1'b0, 1'b0));
            relays[RELAY_ENABLE] = 1'b0;
            model_state = SEQ_READY;
            step_results.push_back(snapshot(1'b0, 1'b1));
         end
         KIND_RESET: begin
            relays[RELAY_FIRE] = 1'b0;
            step_results.push_back(snapshot(1'b0, 1'b0));
            relays[RELAY_SELECT] = 1'b0;
            step_results.push_back(snapshot(1'b0, 1'b0));
            relays[RELAY_ENABLE] = 1'b0;
            step_results.push_back(snapshot(1'b0, 1'b0));
            relays[RELAY_CHARGE] = 1'b0;
            model_state = SEQ_READY;
            step_results.push_back(snapshot(1'b0, 1'b1));
         end
         default: begin
            case (model_state)
               SEQ_B1_CHARGING, SEQ_B2_CHARGING: begin
                  target = (model_state == SEQ_B1_CHARGING) ? cfg.bank1_voltage_target
                                                            : cfg.bank2_voltage_target;
                  // strictly above the target ends the charge
                  if (sensed > target) begin
                     relays[RELAY_CHARGE] = 1'b0;
                     supply_on = 1'b0;
                     model_state = seq_state_type'(model_state + 4'd1);
                  end
               end
               SEQ_B1_CHECKING, SEQ_B2_CHECKING: begin
                  // residual at or above threshold goes to fault, else skip to success
                  model_state = seq_state_type'(model_state +
                     ((sensed >= cfg.residual_threshold) ? 4'd1 : 4'd2));
               end
               SEQ_B1_FAULT, SEQ_B2_FAULT: begin
                  supply_on = 1'b0;
                  fin = 1'b1;
               end
               SEQ_B1_SUCCESS: begin
                  begin_charge(1'b1, cfg.bank2_voltage_target, cfg.bank2_current_target,
                               SEQ_B2_CHARGING);
               end
               SEQ_B2_SUCCESS: begin
                  fin = 1'b1;
               end
               default: begin
                  begin_charge(1'b0, cfg.bank1_voltage_target, cfg.bank1_current_target,
                               SEQ_B1_CHARGING);
               end
            endcase
            step_results.push_back(snapshot(fin, 1'b1));
         end
      endcase
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cfg = '0;
         cfg.residual_threshold = RESIDUAL_RESET;
         model_state = SEQ_READY;
         relays = '0;
         supply_on = 1'b0;
         volt_setpoint = '0;
         curr_setpoint = '0;
         step_results.delete();
      end else begin
         // results first: an item taken at this edge cannot have a result out yet
         if (rsp_valid && !rsp_stall) begin
            if (step_results.size() == 0) begin
               $error("result item arrived with nothing expected");
               fail_count++;
            end else begin
               want = step_results.pop_front();
               check_field("enable_relay", 16'(want.enable_relay),
                           16'(rsp_enable_relay));
               check_field("charge_relay", 16'(want.charge_relay),
                           16'(rsp_charge_relay));
               check_field("select_relay", 16'(want.select_relay),
                           16'(rsp_select_relay));
               check_field("fire_relay", 16'(want.fire_relay), 16'(rsp_fire_relay));
               check_field("supply_output_on", 16'(want.supply_output_on),
                           16'(rsp_supply_output_on));
               check_field("supply_voltage_setpoint", want.supply_voltage_setpoint,
                           rsp_supply_voltage_setpoint);
               check_field("supply_current_setpoint", want.supply_current_setpoint,
                           rsp_supply_current_setpoint);
               check_field("sequence_code", 16'(want.sequence_code),
                           16'(rsp_sequence_code));
               check_field("finished", 16'(want.finished), 16'(rsp_finished));
               check_field("fault", 16'(want.fault), 16'(rsp_fault));
               check_field("last", 16'(want.last), 16'(rsp_last));
            end
         end
         if (req_valid && !req_stall)
            run_command(kind_type'(req_kind), req_sensed_voltage);
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[CSR_ADDR_BITS-1:2]))
               CSR_B1_VOLT:  cfg.bank1_voltage_target = pwdata[15:0];
               CSR_B1_CUR:   cfg.bank1_current_target = pwdata[15:0];
               CSR_B2_VOLT:  cfg.bank2_voltage_target = pwdata[15:0];
               CSR_B2_CUR:   cfg.bank2_current_target = pwdata[15:0];
               CSR_RESIDUAL: cfg.residual_threshold = pwdata[15:0];
               default: ;
            endcase
         end
      end
      outstanding <= step_results.size();
   end

endmodule

`default_nettype wire

FILE: tb/capacitor_bank_charge_sequencer_unit_tb.sv
// stimulus and verdict for the capacitor bank charge sequencer: directed commands,
// then well-formed charge runs with noise under several register settings
// depends on cbcs_pkg, capacitor_bank_charge_sequencer_unit and cbcs_result_monitor
`timescale 1ns / 100ps
`default_nettype none

module capacitor_bank_charge_sequencer_unit_tb;
   import cbcs_pkg::*;

   localparam int          CYCLE_LIMIT     = 300000;
   localparam int          PHASES          = 8;
   localparam int          ITEMS_PER_PHASE = 56;
   localparam logic [2:0]  UNUSED_INDEX    = 3'd5;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_kind;
   logic [15:0]               req_sensed_voltage;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_enable_relay;
   logic                      rsp_charge_relay;
   logic                      rsp_select_relay;
   logic                      rsp_fire_relay;
   logic                      rsp_supply_output_on;
   logic [15:0]               rsp_supply_voltage_setpoint;
   logic [15:0]               rsp_supply_current_setpoint;
   logic [3:0]                rsp_sequence_code;
   logic                      rsp_finished;
   logic                      rsp_fault;
   logic                      rsp_last;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_BITS-1:0]  paddr;
   logic [31:0]               pwdata;
   logic [31:0]               prdata;
   logic                      pready;

   int outstanding;
   int fail_count;
   int cycle_count;
   int item_count;
   bit idle_on;

   // what the stimulus knows of the current settings
   int bank1_volts;
   int bank2_volts;
   int residual;

   capacitor_bank_charge_sequencer_unit u_top (
      .clock                       (clock),
      .reset                       (reset),
      .req_valid                   (req_valid),
      .req_stall                   (req_stall),
      .req_kind                    (req_kind),
      .req_sensed_voltage          (req_sensed_voltage),
      .rsp_valid                   (rsp_valid),
      .rsp_stall                   (rsp_stall),
      .rsp_enable_relay            (rsp_enable_relay),
      .rsp_charge_relay            (rsp_charge_relay),
      .rsp_select_relay            (rsp_select_relay),
      .rsp_fire_relay              (rsp_fire_relay),
      .rsp_supply_output_on        (rsp_supply_output_on),
      .rsp_supply_voltage_setpoint (rsp_supply_voltage_setpoint),
      .rsp_supply_current_setpoint (rsp_supply_current_setpoint),
      .rsp_sequence_code           (rsp_sequence_code),
      .rsp_finished                (rsp_finished),
      .rsp_fault                   (rsp_fault),
      .rsp_last                    (rsp_last),
      .psel                        (psel),
      .penable                     (penable),
      .pwrite                      (pwrite),
      .paddr                       (paddr),
      .pwdata                      (pwdata),
      .prdata                      (prdata),
      .pready                      (pready)
   );

   cbcs_result_monitor u_monitor (
      .clock                       (clock),
      .reset                       (reset),
      .req_valid                   (req_valid),
      .req_stall                   (req_stall),
      .req_kind                    (req_kind),
      .req_sensed_voltage          (req_sensed_voltage),
      .rsp_valid                   (rsp_valid),
      .rsp_stall                   (rsp_stall),
      .rsp_enable_relay            (rsp_enable_relay),
      .rsp_charge_relay            (rsp_charge_relay),
      .rsp_select_relay            (rsp_select_relay),
      .rsp_fire_relay              (rsp_fire_relay),
      .rsp_supply_output_on        (rsp_supply_output_on),
      .rsp_supply_voltage_setpoint (rsp_supply_voltage_setpoint),
      .rsp_supply_current_setpoint (rsp_supply_current_setpoint),
      .rsp_sequence_code           (rsp_sequence_code),
      .rsp_finished                (rsp_finished),
      .rsp_fault                   (rsp_fault),
      .rsp_last                    (rsp_last),
      .psel                        (psel),
      .penable                     (penable),
      .pwrite                      (pwrite),
      .paddr                       (paddr),
      .pwdata                      (pwdata),
      .pready                      (pready),
      .outstanding                 (outstanding),
      .fail_count                  (fail_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver stalls in short bursts
   always @(posedge clock) begin
      if (idle_on && $urandom_range(3, 0) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(3, 1)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_command(kind_type kind, int unsigned volts);
      if (idle_on && $urandom_range(2, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_sensed_voltage <= volts[15:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      item_count++;
   endtask

   // leaves psel high; the caller closes the last transfer
   task automatic write_register(logic [2:0] index, logic [15:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= {16'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (index)
         CSR_B1_VOLT:  bank1_volts = int'(value);
         CSR_B2_VOLT:  bank2_volts = int'(value);
         CSR_RESIDUAL: residual = int'(value);
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [15:0] b1v, logic [15:0] b1c, logic [15:0] b2v,
                                logic [15:0] b2c, logic [15:0] thr);
      write_register(CSR_B1_VOLT, b1v);
      write_register(CSR_B1_CUR, b1c);
      write_register(CSR_B2_VOLT, b2v);
      write_register(CSR_B2_CUR, b2c);
      write_register(CSR_RESIDUAL, thr);
      write_register(UNUSED_INDEX, 16'($urandom_range(65535, 0)));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_level();
      case ($urandom_range(5, 0))
         0: return 16'h0000;
         1: return 16'hffff;
         2: return 16'($urandom_range(40, 1));
         default: return 16'($urandom_range(65535, 0));
      endcase
   endfunction

   // one charge sequence from ready through both banks or into a fault
   task automatic charge_run();
      int  target;
      bit  faulted;
      case ($urandom_range(3, 0))
         0: send_command(KIND_RESET, $urandom_range(65535, 0));
         1: send_command(KIND_FIRE, $urandom_range(65535, 0));
         default: send_command(KIND_PREPARE, $urandom_range(65535, 0));
      endcase
      for (int bank = 0; bank < 2; bank++) begin
         // from ready or bank one success this update starts the charge
         send_command(KIND_UPDATE, $urandom_range(65535, 0));
         target = (bank == 0) ? bank1_volts : bank2_volts;
         repeat ($urandom_range(2, 0)) send_command(KIND_UPDATE, $urandom_range(target, 0));
         // a target at full scale is never exceeded
         if (target == 65535) return;
         send_command(KIND_UPDATE, $urandom_range(65535, target + 1));
         faulted = (residual == 0) || ($urandom_range(1, 0) == 1);
         if (faulted) begin
            send_command(KIND_UPDATE, $urandom_range(65535, residual));
            break;
         end
         send_command(KIND_UPDATE, $urandom_range(residual - 1, 0));
      end
      repeat ($urandom_range(2, 1)) send_command(KIND_UPDATE, $urandom_range(65535, 0));
   endtask

   initial begin
      int phase_start;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_kind <= KIND_UPDATE;
      req_sensed_voltage <= '0;
      rsp_stall <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      idle_on = 1'b1;
      item_count = 0;
      bank1_volts = 0;
      bank2_volts = 0;
      residual = int'(RESIDUAL_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: targets zero, residual threshold ten
      send_command(KIND_UPDATE, 16'd0);
      send_command(KIND_UPDATE, 16'd0);
      send_command(KIND_UPDATE, 16'd1);
      send_command(KIND_UPDATE, 16'd10);
      send_command(KIND_UPDATE, 16'hffff);
      send_command(KIND_PREPARE, 16'hffff);
      send_command(KIND_UPDATE, 16'd0);
      send_command(KIND_UPDATE, 16'hffff);
      send_command(KIND_UPDATE, 16'd9);
      send_command(KIND_UPDATE, 16'd0);
      send_command(KIND_UPDATE, 16'd0);
      send_command(KIND_UPDATE, 16'hffff);
      send_command(KIND_UPDATE, 16'd0);
      send_command(KIND_UPDATE, 16'd0);
      send_command(KIND_FIRE, 16'h5555);
      send_command(KIND_UPDATE, 16'd0);
      send_command(KIND_UPDATE, 16'd5);
      send_command(KIND_UPDATE, 16'd5);
      send_command(KIND_UPDATE, 16'd100);
      send_command(KIND_UPDATE, 16'd1);
      send_command(KIND_UPDATE, 16'd10);
      send_command(KIND_UPDATE, 16'd3);
      send_command(KIND_RESET, 16'haaaa);
      send_command(KIND_RESET, 16'd0);
      send_command(KIND_PREPARE, 16'd0);
      send_command(KIND_FIRE, 16'd0);

      for (int phase = 0; phase < PHASES; phase++) begin
         // sender holds off until every result is back before touching registers
         req_valid <= 1'b0;
         wait_idle();
         case (phase)
            0: load_settings(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
            1: load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
            default: load_settings(pick_level(), 16'($urandom_range(65535, 0)),
                                   pick_level(), 16'($urandom_range(65535, 0)),
                                   pick_level());
         endcase
         phase_start = item_count;
         while (item_count - phase_start < ITEMS_PER_PHASE) begin
            idle_on = (phase != PHASES - 1) && ($urandom_range(3, 0) != 0);
            if ($urandom_range(4, 0) == 0) begin
               repeat ($urandom_range(4, 1))
                  send_command(kind_type'($urandom_range(3, 0)), $urandom_range(65535, 0));
            end else begin
               charge_run();
            end
         end
      end

      req_valid <= 1'b0;
      wait_idle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
rtl/cbcs_pkg.sv
rtl/cbcs_csr.sv
rtl/cbcs_seq.sv
rtl/cbcs_out.sv
rtl/capacitor_bank_charge_sequencer_unit.sv
rtl/cbcs_checker.sv
tb/cbcs_result_monitor.sv
tb/capacitor_bank_charge_sequencer_unit_tb.sv
